FILE: design/sha256_byte_stream_hasher_macros.svh
// Assertion macros for the SHA-256 byte stream hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`ifndef SYNTH
// Concurrent implication check, clocked on clk with asynchronous reset.
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication check.
`define SHA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SHA_ASSERT_IMP(label, ante, cons, msg)
`define SHA_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

FILE: design/sha256_pkg.sv
// Package: SHA-256 constants and round functions.
package sha256_pkg;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	typedef logic [31:0] word_t;

	function automatic word_t ror32(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t sig_s0(input word_t x);
		return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig_s1(input word_t x);
		return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t big_s0(input word_t x);
		return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic word_t big_s1(input word_t x);
		return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

endpackage

FILE: design/sha256_byte_stream_hasher.sv
// SHA-256 byte stream hasher: top level with block buffer memory and round engine.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, msg_byte, byte_valid, last  | in
//  output  | out_valid, out_stall, digest_word, word_index, last_word | out
//
// An accepted byte is written into a 16 x 32-bit word memory.
// The 64th byte, and each final block, starts compression: ST_LOAD fills the
// schedule window from the memory (one read a cycle, data the cycle after),
// then ST_RND runs 64 rounds at one a cycle and ST_ADD adds the chaining value.
// A final item writes padding words before each final block, then eight digest
// transactions. Reset clears control state and the chaining value; the buffer
// memory needs no clearing. out_stall holds the current digest word.
module sha256_byte_stream_hasher
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  msg_byte,
	input  logic        byte_valid,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
`include "sha256_byte_stream_hasher_macros.svh"

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PAD  = 4'd1;  // write padding words
	localparam logic [3:0] ST_LOAD = 4'd2;  // read 16 words into window
	localparam logic [3:0] ST_RND  = 4'd3;  // 64 rounds
	localparam logic [3:0] ST_ADD  = 4'd4;  // add chaining value
	localparam logic [3:0] ST_OUT  = 4'd5;  // emit digest words

	logic [3:0]  state_q;
	logic [5:0]  fill_q;
	logic [63:0] bitlen_q;
	logic        fin_q;     // block was filled by a last byte
	logic        second_q;  // final pass needs another block after this one
	logic        lenblk_q;  // current padding block holds only zeros and length
	logic        finishing_q;
	logic [5:0]  fill_fin_q;
	logic [6:0]  cnt_q;
	word_t       h_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	logic [31:0] part_q;    // bytes of the word being gathered

	// Block buffer memory, 16 words
	word_t       mem [16];
	logic        mem_we;
	logic [3:0]  mem_wa;
	word_t       mem_wd;
	logic [3:0]  mem_ra;
	word_t       mem_rd_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	logic acc_in, acc_out;
	assign in_stall  = (state_q != ST_IDLE);
	assign acc_in    = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign acc_out   = out_valid && !out_stall;

	// Byte merged into the partial word
	logic [31:0] merged;
	always_comb begin
		merged = part_q;
		case (fill_q[1:0])
			2'd0: merged = {msg_byte, 24'd0};
			2'd1: merged[23:16] = msg_byte;
			2'd2: merged[15:8] = msg_byte;
			default: merged[7:0] = msg_byte;
		endcase
	end

	// Padding word for index cnt_q[3:0] of a final block
	logic [31:0] pad_word;
	logic [5:0]  wbase;
	always_comb begin
		wbase = {cnt_q[3:0], 2'b00};
		pad_word = '0;
		if (cnt_q[3:0] == 4'd14 && !second_q)
			pad_word = bitlen_q[63:32];
		else if (cnt_q[3:0] == 4'd15 && !second_q)
			pad_word = bitlen_q[31:0];
		else if (fill_fin_q[5:2] == cnt_q[3:0] && !lenblk_q) begin
			pad_word = part_q;
			case (fill_fin_q[1:0])
				2'd0: pad_word = {PAD_BYTE, 24'd0};
				2'd1: pad_word[23:0] = {PAD_BYTE, 16'd0};
				2'd2: pad_word[15:0] = {PAD_BYTE, 8'd0};
				default: pad_word[7:0] = PAD_BYTE;
			endcase
		end
	end

	// Round logic
	word_t w_new, x_t, y_t, k_t, w_cur;
	always_comb begin
		w_new = sig_s1(w_q[14]) + w_q[9] + sig_s0(w_q[1]) + w_q[0];
		k_t   = ROUND_K[cnt_q[5:0]];
		w_cur = w_q[0];
		x_t = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ k_t + w_cur;
		y_t = big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// Memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_wa = fill_q[5:2];
		mem_wd = merged;
		mem_ra = cnt_q[3:0];
		if (state_q == ST_IDLE && acc_in && byte_valid) begin
			mem_we = 1'b1;
		end else if (state_q == ST_PAD) begin
			mem_we = (wbase >= {fill_fin_q[5:2], 2'b00}) || lenblk_q;
			mem_wa = cnt_q[3:0];
			mem_wd = pad_word;
		end
	end

	// Control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			bitlen_q   <= '0;
			fin_q      <= 1'b0;
			second_q   <= 1'b0;
			lenblk_q   <= 1'b0;
			fill_fin_q <= '0;
			cnt_q      <= '0;
			for (int i = 0; i < 8; i++)
				h_q[i] <= INIT_H[i];
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc_in) begin
						if (byte_valid) begin
							fill_q <= fill_q + 6'd1;
							if (fill_q == 6'd63) begin
								bitlen_q <= bitlen_q + 64'd512;
								cnt_q    <= '0;
								fin_q    <= last;  // finish after the block
								second_q <= 1'b0;
								state_q  <= ST_LOAD;
							end else if (last) begin
								fill_fin_q <= fill_q + 6'd1;
								bitlen_q   <= bitlen_q + {55'd0, fill_q + 6'd1, 3'd0};
								second_q   <= (fill_q + 6'd1) >= LEN_POS;
								fin_q      <= 1'b0;
								lenblk_q   <= 1'b0;
								cnt_q      <= '0;
								state_q    <= ST_PAD;
							end
						end else if (last) begin
							fill_fin_q <= fill_q;
							bitlen_q   <= bitlen_q + {55'd0, fill_q, 3'd0};
							second_q   <= fill_q >= LEN_POS;
							fin_q      <= 1'b0;
							lenblk_q   <= 1'b0;
							cnt_q      <= '0;
							state_q    <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q[3:0] == 4'd15) begin
						cnt_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					// read issued at cnt, data arrives next cycle
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q != 7'd0)
						w_q[cnt_q[3:0] - 4'd1] <= mem_rd_q;
					if (cnt_q == 7'd16) begin
						cnt_q <= '0;
						for (int i = 0; i < 8; i++)
							v_q[i] <= h_q[i];
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					v_q[7] <= v_q[6];
					v_q[6] <= v_q[5];
					v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + x_t;
					v_q[3] <= v_q[2];
					v_q[2] <= v_q[1];
					v_q[1] <= v_q[0];
					v_q[0] <= x_t + y_t;
					for (int i = 0; i < 15; i++)
						w_q[i] <= w_q[i + 1];
					w_q[15] <= w_new;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd63)
						state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= h_q[i] + v_q[i];
					cnt_q <= '0;
					if (fin_q) begin
						// block filled by a last byte: pad an empty tail
						fin_q      <= 1'b0;
						fill_fin_q <= '0;
						second_q   <= 1'b0;
						lenblk_q   <= 1'b0;
						fill_q     <= '0;
						state_q    <= ST_PAD;
					end else if (second_q) begin
						// second final block: zeros then length
						second_q   <= 1'b0;
						lenblk_q   <= 1'b1;
						fill_fin_q <= '0;
						state_q    <= ST_PAD;
					end else if (finishing_q) begin
						lenblk_q <= 1'b0;
						state_q  <= ST_OUT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (acc_out) begin
						cnt_q <= cnt_q + 7'd1;
						if (cnt_q[2:0] == 3'd7) begin
							state_q  <= ST_IDLE;
							fill_q   <= '0;
							bitlen_q <= '0;
							cnt_q    <= '0;
							for (int i = 0; i < 8; i++)
								h_q[i] <= INIT_H[i];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Marks a padding pass in flight, so ADD knows to emit the digest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			finishing_q <= 1'b0;
		else if (state_q == ST_PAD)
			finishing_q <= 1'b1;
		else if (state_q == ST_OUT)
			finishing_q <= 1'b0;
	end

	// Partial word register
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc_in && byte_valid)
			part_q <= merged;
	end

	assign digest_word = h_q[cnt_q[2:0]];
	assign word_index  = cnt_q[2:0];
	assign last_word   = (cnt_q[2:0] == 3'd7);

	`SHA_ASSERT_IMP(a_out_only_in_out, out_valid, state_q == ST_OUT, "output outside digest phase")
	`SHA_ASSERT_IMP(a_stall_busy, state_q != ST_IDLE, in_stall, "input taken while busy")
	`SHA_ASSERT_NXT(a_last_word_ret, acc_out && last_word, state_q == ST_IDLE, "no idle after word 7")
	`SHA_ASSERT_IMP(a_round_cnt, state_q == ST_RND, cnt_q < 7'd64, "round counter overrun")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the SHA-256 byte stream hasher.
`timescale 1ns / 1ps

module testbench
	import sha256_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int MSG_COUNT = 16;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       byte_valid;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_item_t;

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  msg_byte;
	logic        byte_valid;
	logic        last;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha256_byte_stream_hasher u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.msg_byte(msg_byte), .byte_valid(byte_valid), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	// Hasher mirror state
	logic [7:0]  blk_bytes [64];
	int unsigned blk_fill;
	logic [63:0] msg_bits;
	word_t       chain [8];

	byte_item_t   pending_bytes [$];
	digest_item_t expected_digests [$];

	int  mismatches;
	int  digests_seen;
	int  msgs_sent;
	bit  stim_done;
	bit  quiet_mode;
	bit  long_hold_req;
	bit  timed_out;
	bit  in_acc_seen;
	int  idle_cycles;

	function automatic word_t rotr(word_t x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic void hash_init();
		blk_fill = 0;
		msg_bits = '0;
		for (int i = 0; i < 8; i++) chain[i] = H_INIT[i];
	endfunction

	function automatic void compress();
		word_t w [64];
		word_t v [8];
		word_t t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		for (int i = 0; i < 8; i++) v[i] = chain[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain[i] += v[i];
	endfunction

	// Advance the mirror by one accepted transaction; queue digest words on last
	function automatic void absorb_byte(byte_item_t it);
		int unsigned p;
		digest_item_t d;
		if (it.byte_valid) begin
			blk_bytes[blk_fill] = it.msg_byte;
			blk_fill++;
			if (blk_fill == 64) begin
				compress();
				msg_bits += 64'd512;
				blk_fill = 0;
			end
		end
		if (!it.last) return;
		msg_bits += 64'(blk_fill * 8);
		p = blk_fill;
		blk_bytes[p++] = 8'h80;
		if (blk_fill >= 56) begin
			while (p < 64) blk_bytes[p++] = 8'h00;
			compress();
			p = 0;
		end
		while (p < 56) blk_bytes[p++] = 8'h00;
		for (int i = 0; i < 8; i++) blk_bytes[56+i] = msg_bits[63-8*i -: 8];
		compress();
		for (int i = 0; i < 8; i++) begin
			d.digest_word = chain[i];
			d.word_index = 3'(i);
			d.last_word = (i == 7);
			expected_digests.push_back(d);
		end
		hash_init();
	endfunction

	function automatic void queue_message(int len, bit tail_invalid, int fill_mode);
		byte_item_t it;
		for (int i = 0; i < len; i++) begin
			case (fill_mode)
				0: it.msg_byte = 8'($urandom_range(0, 255));
				1: it.msg_byte = 8'hff;
				default: it.msg_byte = 8'h00;
			endcase
			it.byte_valid = 1'b1;
			it.last = (i == len - 1) && !tail_invalid;
			// odd ignored gap transaction
			if ($urandom_range(0, 19) == 0)
				pending_bytes.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
			pending_bytes.push_back(it);
		end
		if (tail_invalid || len == 0)
			pending_bytes.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b1});
		msgs_sent++;
	endfunction

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Stimulus plan
	initial begin
		int lens [$];
		arst_n = 1'b0;
		stim_done = 1'b0;
		quiet_mode = 1'b0;
		long_hold_req = 1'b0;
		msgs_sent = 0;
		hash_init();
		for (int i = 0; i < 64; i++) blk_bytes[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: empty, single bytes, padding boundaries
		queue_message(0, 1'b1, 0);
		queue_message(1, 1'b0, 1);
		queue_message(1, 1'b0, 2);
		queue_message(3, 1'b1, 0);
		queue_message(5, 1'b0, 0);
		wait (pending_bytes.size() == 0);
		long_hold_req = 1'b1;
		lens = '{55, 56, 63, 64, 70, 8, 2, 7};
		foreach (lens[i]) queue_message(lens[i], lens[i] == 64, 0);
		// sender pauses until all digests are out
		wait (pending_bytes.size() == 0 && expected_digests.size() == 0);
		for (int i = 0; i < MSG_COUNT - 13; i++) begin
			if (i == MSG_COUNT - 15) begin
				wait (pending_bytes.size() == 0);
				quiet_mode = 1'b1;
			end
			queue_message($urandom_range(0, 3) == 0 ? $urandom_range(50, 70)
				: $urandom_range(0, 20), $urandom_range(0, 3) == 0, 0);
		end
		stim_done = 1'b1;
	end

	// Input acceptance seen at the last rising edge
	always @(posedge clk) begin
		in_acc_seen <= arst_n && in_valid && !in_stall;
	end

	// Driver
	int send_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			msg_byte <= '0;
			byte_valid <= 1'b0;
			last <= 1'b0;
			send_gap <= 0;
		end else if (!in_valid || in_acc_seen) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_bytes.size() != 0) begin
				in_valid <= 1'b1;
				{msg_byte, byte_valid, last} <= pending_bytes.pop_front();
				if (!quiet_mode && $urandom_range(0, 9) == 0)
					send_gap <= $urandom_range(1, 9);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall, including one long hold
	int stall_left;
	bit long_hold_done;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			long_hold_done <= 1'b0;
		end else if (long_hold_req && !long_hold_done) begin
			out_stall <= 1'b1;
			stall_left <= 600;
			long_hold_done <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 8);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor and scoreboard
	always @(posedge clk) begin
		digest_item_t exp_d;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (in_valid && !in_stall)
				absorb_byte('{msg_byte, byte_valid, last});
			if (out_valid && !out_stall) begin
				digests_seen++;
				if (expected_digests.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected digest transaction: word %h index %0d",
							digest_word, word_index);
				end else begin
					exp_d = expected_digests.pop_front();
					if (exp_d != {digest_word, word_index, last_word}) begin
						mismatches++;
						if (mismatches <= 10)
							$display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
								exp_d.digest_word, exp_d.word_index, exp_d.last_word,
								digest_word, word_index, last_word);
					end
				end
			end
		end
	end

	// Completion and watchdog
	initial begin
		mismatches = 0;
		digests_seen = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		@(posedge arst_n);
		while (!(stim_done && pending_bytes.size() == 0 && !in_valid
				&& expected_digests.size() == 0) && !timed_out) begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
		end
		if (!timed_out) repeat (200) @(posedge clk);
		$display("covered %0d messages, %0d digest words checked",
			msgs_sent, digests_seen);
		if (timed_out) $display("watchdog expired with %0d words outstanding",
			expected_digests.size());
		if (!timed_out && mismatches == 0 && expected_digests.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
